### hw/rtl/cmsp_pkg.sv
// Shared types and constants of the chunked mesh stream parser.
package cmsp_pkg;

   // Result record kinds
   localparam logic [2:0] KIND_VTX_COUNT = 3'd0;
   localparam logic [2:0] KIND_VTX_WORD  = 3'd1;
   localparam logic [2:0] KIND_FACE_COUNT = 3'd2;
   localparam logic [2:0] KIND_FACE_INDEX = 3'd3;
   localparam logic [2:0] KIND_UV_COUNT  = 3'd4;
   localparam logic [2:0] KIND_UV_WORD   = 3'd5;
   localparam logic [2:0] KIND_END       = 3'd6;

   // Chunk ids
   localparam logic [15:0] ID_MAIN      = 16'h4D4D;
   localparam logic [15:0] ID_EDITOR    = 16'h3D3D;
   localparam logic [15:0] ID_OBJECT    = 16'h4000;
   localparam logic [15:0] ID_TRIMESH   = 16'h4100;
   localparam logic [15:0] ID_VERTICES  = 16'h4110;
   localparam logic [15:0] ID_FACES     = 16'h4120;
   localparam logic [15:0] ID_UVS       = 16'h4140;
   localparam logic [15:0] ID_MATERIAL  = 16'hAFFF;
   localparam logic [15:0] ID_MAT_AMB   = 16'hA200;
   localparam logic [15:0] ID_MAT_NAME  = 16'hA300;

   localparam logic [31:0] HEADER_BYTES = 32'd6;

   // Queue depth of the result buffer
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [15:0] element_index;
      logic [1:0]  component;
      logic [31:0] record_value;
   } rec_type;

   // Up to two records per byte; slot 0 always fills first
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rec_type rec0;
      rec_type rec1;
   } push_type;

endpackage

### hw/rtl/cmsp_parser.sv
// Chunk header walker and list decoder: one byte in, up to two records out.
module cmsp_parser
   import cmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   input  logic       final_byte,
   output push_type   push
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_NAME   = 3'd1,
      PH_SKIP   = 3'd2,
      PH_COUNT  = 3'd3,
      PH_LIST   = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hbc_ff, hbc_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  biw_ff, biw_in;
   logic [15:0] entry_ff, entry_in;
   logic [1:0]  comp_ff, comp_in;
   logic [15:0] vtot_ff, vtot_in;
   logic [15:0] ftot_ff, ftot_in;
   logic [15:0] utot_ff, utot_in;

   always_comb begin
      logic [2:0]  h;
      logic [15:0] id_v;
      logic [31:0] len_v;
      logic [31:0] skip_v;
      logic [31:0] skip_dec;
      logic [15:0] cnt;
      logic [15:0] total;
      logic [15:0] dtotal;
      logic [15:0] entry_v;
      logic [31:0] word_v;
      logic [2:0]  wplus;
      logic [2:0]  wbytes;
      logic [2:0]  ncomp;
      logic [2:0]  cnext;
      logic [2:0]  kind_count;
      logic [2:0]  kind_word;
      rec_type     rec;
      logic        emit;

      phase_in = phase_ff;
      hbc_in   = hbc_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      word_in  = word_ff;
      biw_in   = biw_ff;
      entry_in = entry_ff;
      comp_in  = comp_ff;
      vtot_in  = vtot_ff;
      ftot_in  = ftot_ff;
      utot_in  = utot_ff;
      push     = '0;
      rec      = '0;
      emit     = 1'b0;

      h        = (hbc_ff > 3'd5) ? 3'd0 : hbc_ff;
      id_v     = id_ff;
      len_v    = len_ff;
      cnt      = {data_byte, word_ff[7:0]};
      skip_dec = skip_ff - 32'd1;
      word_v   = word_ff | ({24'd0, data_byte} << {biw_ff, 3'b000});
      wplus    = {1'b0, biw_ff} + 3'd1;
      cnext    = {1'b0, comp_ff} + 3'd1;
      entry_v  = entry_ff + 16'd1;

      // List selected by the current chunk id: vertices, faces, else uvs
      case (id_ff)
         ID_VERTICES: begin
            total = vtot_ff; wbytes = 3'd4; ncomp = 3'd3;
            kind_count = KIND_VTX_COUNT; kind_word = KIND_VTX_WORD;
         end
         ID_FACES: begin
            total = ftot_ff; wbytes = 3'd2; ncomp = 3'd4;
            kind_count = KIND_FACE_COUNT; kind_word = KIND_FACE_INDEX;
         end
         default: begin
            total = utot_ff; wbytes = 3'd4; ncomp = 3'd2;
            kind_count = KIND_UV_COUNT; kind_word = KIND_UV_WORD;
         end
      endcase

      // Header assembly, little endian
      case (h)
         3'd0: begin
            id_v  = {8'd0, data_byte};
            len_v = '0;
         end
         3'd1:    id_v  = id_ff | {data_byte, 8'd0};
         3'd2:    len_v = len_ff | {24'd0, data_byte};
         3'd3:    len_v = len_ff | {16'd0, data_byte, 8'd0};
         3'd4:    len_v = len_ff | {8'd0, data_byte, 16'd0};
         default: len_v = len_ff | {data_byte, 24'd0};
      endcase
      skip_v = (len_v > HEADER_BYTES) ? (len_v - HEADER_BYTES) : '0;

      case (id_v)
         ID_VERTICES: dtotal = vtot_ff;
         ID_FACES:    dtotal = ftot_ff;
         default:     dtotal = utot_ff;
      endcase

      if (byte_valid) begin
         case (phase_ff)
            PH_HEADER: begin
               id_in  = id_v;
               len_in = len_v;
               if (h == 3'd5) begin
                  hbc_in = '0;
                  if (id_v inside {ID_MAIN, ID_EDITOR, ID_TRIMESH, ID_MATERIAL,
                                   ID_MAT_AMB}) begin
                     phase_in = PH_HEADER;
                  end else if (id_v inside {ID_OBJECT, ID_MAT_NAME}) begin
                     phase_in = PH_NAME;
                  end else if ((id_v inside {ID_VERTICES, ID_FACES, ID_UVS}) &&
                               (dtotal == 16'd0)) begin
                     word_in  = '0;
                     biw_in   = '0;
                     phase_in = PH_COUNT;
                  end else begin
                     skip_in  = skip_v;
                     phase_in = (skip_v == 32'd0) ? PH_HEADER : PH_SKIP;
                  end
               end else begin
                  hbc_in = h + 3'd1;
               end
            end
            PH_NAME: begin
               if (data_byte == 8'd0) phase_in = PH_HEADER;
            end
            PH_SKIP: begin
               if (skip_ff != 32'd0) skip_in = skip_dec;
               if (skip_ff <= 32'd1) phase_in = PH_HEADER;
            end
            PH_COUNT: begin
               if (biw_ff[0]) begin
                  case (id_ff)
                     ID_VERTICES: vtot_in = cnt;
                     ID_FACES:    ftot_in = cnt;
                     default:     utot_in = cnt;
                  endcase
                  emit     = 1'b1;
                  rec      = '{record_kind: kind_count, element_index: '0,
                               component: '0, record_value: {16'd0, cnt}};
                  word_in  = '0;
                  biw_in   = '0;
                  entry_in = '0;
                  comp_in  = '0;
                  phase_in = (cnt != 16'd0) ? PH_LIST : PH_HEADER;
               end else begin
                  word_in = word_ff | {24'd0, data_byte};
                  biw_in  = 2'd1;
               end
            end
            PH_LIST: begin
               if (wplus >= wbytes) begin
                  biw_in = '0;
                  // the face flag word (component 3) is dropped
                  if (({1'b0, comp_ff} < 3'd3) && ({1'b0, comp_ff} < ncomp)) begin
                     emit = 1'b1;
                     rec  = '{record_kind: kind_word, element_index: entry_ff,
                              component: comp_ff, record_value: word_v};
                  end
                  word_in = '0;
                  if (cnext >= ncomp) begin
                     cnext    = '0;
                     entry_in = entry_v;
                     if (entry_v >= total) phase_in = PH_HEADER;
                  end
                  comp_in = cnext[1:0];
               end else begin
                  word_in = word_v;
                  biw_in  = wplus[1:0];
               end
            end
            default: phase_in = PH_HEADER;
         endcase

         push.valid0 = emit;
         push.rec0   = rec;

         if (final_byte) begin
            if (emit) begin
               push.valid1 = 1'b1;
               push.rec1   = '{record_kind: KIND_END, element_index: '0,
                               component: '0, record_value: '0};
            end else begin
               push.valid0 = 1'b1;
               push.rec0   = '{record_kind: KIND_END, element_index: '0,
                               component: '0, record_value: '0};
            end
            phase_in = PH_HEADER;
            hbc_in   = '0;
            id_in    = '0;
            len_in   = '0;
            skip_in  = '0;
            word_in  = '0;
            biw_in   = '0;
            entry_in = '0;
            comp_in  = '0;
            vtot_in  = '0;
            ftot_in  = '0;
            utot_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hbc_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         skip_ff  <= '0;
         word_ff  <= '0;
         biw_ff   <= '0;
         entry_ff <= '0;
         comp_ff  <= '0;
         vtot_ff  <= '0;
         ftot_ff  <= '0;
         utot_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hbc_ff   <= hbc_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         skip_ff  <= skip_in;
         word_ff  <= word_in;
         biw_ff   <= biw_in;
         entry_ff <= entry_in;
         comp_ff  <= comp_in;
         vtot_ff  <= vtot_in;
         ftot_ff  <= ftot_in;
         utot_ff  <= utot_in;
      end
   end

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0)
      else $error("second record without a first");

   a_slot1_end: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> (push.rec1.record_kind == KIND_END && final_byte))
      else $error("second record is not an end record");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && final_byte) |=>
         (phase_ff == PH_HEADER && hbc_ff == 3'd0 && vtot_ff == 16'd0 &&
          ftot_ff == 16'd0 && utot_ff == 16'd0))
      else $error("parser state not cleared after last byte");

endmodule

### hw/rtl/cmsp_queue.sv
// Small result queue: takes up to two records per cycle, hands out one.
module cmsp_queue
   import cmsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     has_room_two,
   output logic     not_empty,
   output rec_type  head
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   rec_type        mem [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [PW-1:0]  wr_ptr_next;
   logic [CW-1:0]  push_cnt;
   logic           do_pop;

   assign wr_ptr_next  = wr_ptr_ff + PW'(1);
   assign push_cnt     = CW'(push.valid0) + CW'(push.valid1);
   assign do_pop       = pop && (count_ff != '0);
   assign not_empty    = (count_ff != '0);
   assign has_room_two = (count_ff <= CW'(QUEUE_DEPTH - 2));
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_cnt);
      rd_ptr_in = do_pop ? (rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = count_ff + push_cnt - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid0) mem[wr_ptr_ff]   <= push.rec0;
      if (push.valid1) mem[wr_ptr_next] <= push.rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && push_cnt == '0) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count wrong after a pop");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PW-1:0])
      else $error("queue pointers disagree with count");

endmodule

### hw/rtl/chunked_mesh_stream_parser_top.sv
// Top level of the chunked mesh stream parser.
// Walks a 3DS-style chunked file that arrives one byte per transfer on the req_
// side and sends mesh records on the rsp_ side. Each chunk header (16-bit id,
// 32-bit length, little endian) is decoded; container chunks are entered, name
// chunks are skipped through their zero terminator, other chunks are skipped by
// length minus 6. The first vertex, face and texture-coordinate lists are
// decoded: first a count record, then one record per raw 32-bit coordinate word
// or 16-bit face index (the face flag word is dropped). A byte with req_tlast
// set closes the file: any record it completes goes out, then an end record,
// and the parser returns to its reset state. Rate: one byte per clock
// sustained; each byte is decoded in the cycle it is taken and its records
// land in a four-entry result queue, so req_tready stays high while the queue
// has room for two records and only drops when rsp_tready holds records off.
module chunked_mesh_stream_parser_top
   import cmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   // record stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] element_index, [17:16] component,
                                    // [49:18] record_value, [55:50] zero
   output logic [2:0]  rsp_tuser    // [2:0] record_kind
);

   push_type push;
   rec_type  head;
   logic     room_two;
   logic     req_xfer;

   // a byte may give two records (last list word plus end), so hold off
   // unless the queue can take both
   assign req_tready = room_two;
   assign req_xfer   = req_tvalid && req_tready;

   cmsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_xfer),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .push       (push)
   );

   cmsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (rsp_tready),
      .has_room_two (room_two),
      .not_empty    (rsp_tvalid),
      .head         (head)
   );

   // pack result fields, lowest field first
   assign rsp_tdata = {6'd0, head.record_value, head.component, head.element_index};
   assign rsp_tuser = head.record_kind;

endmodule

### tb/tb.sv
// Self-checking bench for the chunked mesh stream parser: directed table, then random files.
module tb;
   import cmsp_pkg::*;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_NAME,
      ST_SKIP,
      ST_COUNT,
      ST_LIST
   } walk_state_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;   // rec is the one record this byte must produce
      rec_type    rec;
   } stim_row_type;

   localparam rec_type NO_REC  = '0;
   localparam rec_type END_REC = '{KIND_END, 16'd0, 2'd0, 32'd0};
   localparam rec_type UV_NONE = '{KIND_UV_COUNT, 16'd0, 2'd0, 32'd0};
   localparam int      RANDOM_BYTES = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   // parser state mirror
   walk_state_type walk_state;
   logic [2:0]  hdr_count;
   logic [15:0] chunk_id;
   logic [31:0] chunk_len;
   logic [31:0] skip_left;
   logic [31:0] word_acc;
   logic [1:0]  word_byte;
   logic [15:0] entry_idx;
   logic [1:0]  comp_idx;
   logic [15:0] vtx_total;
   logic [15:0] face_total;
   logic [15:0] uv_total;

   rec_type     step_records[$];
   rec_type     pending_records[$];
   logic [7:0]  file_bytes[$];
   rec_type     got_rec;
   int          error_count = 0;
   bit          req_no_gaps = 1'b0;
   bit          rsp_free_run = 1'b0;
   int          rsp_stall = 0;

   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b1, 1'b1, END_REC},   // end record straight out of reset
      '{8'h40, 1'b0, 1'b0, NO_REC},    // uv list, length all ones
      '{8'h41, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},    // zero count
      '{8'h00, 1'b0, 1'b1, UV_NONE},
      '{8'hFF, 1'b0, 1'b0, NO_REC},    // unknown id, length 0: skip saturates
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},    // object name chunk
      '{8'h40, 1'b0, 1'b0, NO_REC},
      '{8'h07, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h41, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},    // terminator
      '{8'h10, 1'b0, 1'b0, NO_REC},    // vertex header cut by the last byte
      '{8'h41, 1'b1, 1'b1, END_REC}
   };

   always #6 clock = ~clock;

   chunked_mesh_stream_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   task automatic clear_parse_state();
      walk_state = ST_HEADER;
      hdr_count  = '0;
      chunk_id   = '0;
      chunk_len  = '0;
      skip_left  = '0;
      word_acc   = '0;
      word_byte  = '0;
      entry_idx  = '0;
      comp_idx   = '0;
      vtx_total  = '0;
      face_total = '0;
      uv_total   = '0;
   endtask

   task automatic begin_skip();
      skip_left  = (chunk_len > HEADER_BYTES) ? chunk_len - HEADER_BYTES : 32'd0;
      walk_state = (skip_left == 0) ? ST_HEADER : ST_SKIP;
   endtask

   task automatic begin_count();
      word_acc   = '0;
      word_byte  = '0;
      walk_state = ST_COUNT;
   endtask

   // Records one accepted byte produces, left in step_records.
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      int          w;
      int          c;
      int          wbytes;
      int          ncomp;
      logic [15:0] total;
      logic [15:0] cnt;
      logic [2:0]  kind;
      step_records.delete();
      case (walk_state)
         ST_HEADER: begin
            case (hdr_count)
               3'd0: begin
                  chunk_id  = {8'h00, b};
                  chunk_len = '0;
               end
               3'd1: chunk_id[15:8] = b;
               default: chunk_len = chunk_len | (32'(b) << (8 * (hdr_count - 3'd2)));
            endcase
            if (hdr_count == 3'd5) begin
               hdr_count = '0;
               case (chunk_id)
                  ID_MAIN, ID_EDITOR, ID_TRIMESH, ID_MATERIAL, ID_MAT_AMB:
                     walk_state = ST_HEADER;
                  ID_OBJECT, ID_MAT_NAME: walk_state = ST_NAME;
                  ID_VERTICES: if (vtx_total == 0) begin_count(); else begin_skip();
                  ID_FACES: if (face_total == 0) begin_count(); else begin_skip();
                  ID_UVS: if (uv_total == 0) begin_count(); else begin_skip();
                  default: begin_skip();
               endcase
            end else begin
               hdr_count = hdr_count + 3'd1;
            end
         end
         ST_NAME: if (b == 8'h00) walk_state = ST_HEADER;
         ST_SKIP: begin
            if (skip_left > 0) skip_left = skip_left - 1;
            if (skip_left == 0) walk_state = ST_HEADER;
         end
         ST_COUNT: begin
            w = int'(word_byte[0]);
            word_acc = word_acc | (32'(b) << (8 * w));
            if (w == 1) begin
               cnt = word_acc[15:0];
               case (chunk_id)
                  ID_VERTICES: begin
                     vtx_total = cnt;
                     kind = KIND_VTX_COUNT;
                  end
                  ID_FACES: begin
                     face_total = cnt;
                     kind = KIND_FACE_COUNT;
                  end
                  default: begin
                     uv_total = cnt;
                     kind = KIND_UV_COUNT;
                  end
               endcase
               step_records.push_back(rec_type'{kind, 16'd0, 2'd0, {16'd0, cnt}});
               word_acc   = '0;
               word_byte  = '0;
               entry_idx  = '0;
               comp_idx   = '0;
               walk_state = (cnt != 0) ? ST_LIST : ST_HEADER;
            end else begin
               word_byte = 2'd1;
            end
         end
         ST_LIST: begin
            case (chunk_id)
               ID_VERTICES: begin
                  wbytes = 4; ncomp = 3; total = vtx_total; kind = KIND_VTX_WORD;
               end
               ID_FACES: begin
                  wbytes = 2; ncomp = 4; total = face_total; kind = KIND_FACE_INDEX;
               end
               default: begin
                  wbytes = 4; ncomp = 2; total = uv_total; kind = KIND_UV_WORD;
               end
            endcase
            w = int'(word_byte);
            word_acc = word_acc | (32'(b) << (8 * w));
            w = w + 1;
            if (w >= wbytes) begin
               word_byte = '0;
               // fourth face word is the flag word, dropped
               if (comp_idx < 3 && comp_idx < ncomp)
                  step_records.push_back(rec_type'{kind, entry_idx, comp_idx, word_acc});
               word_acc = '0;
               c = int'(comp_idx) + 1;
               if (c >= ncomp) begin
                  c = 0;
                  entry_idx = entry_idx + 16'd1;
                  if (entry_idx >= total) walk_state = ST_HEADER;
               end
               comp_idx = c[1:0];
            end else begin
               word_byte = w[1:0];
            end
         end
         default: walk_state = ST_HEADER;
      endcase
      if (fin) begin
         step_records.push_back(END_REC);
         clear_parse_state();
      end
   endtask

   // One byte transfer on the req side, then predict what it produces.
   task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                            input rec_type typed_rec);
      int gap;
      gap = req_no_gaps ? 0 : int'($urandom_range(0, 5));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, fin);
      if (typed) pending_records.push_back(typed_rec);
      else foreach (step_records[i]) pending_records.push_back(step_records[i]);
   endtask

   task automatic put_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++) file_bytes.push_back(value[8*i +: 8]);
   endtask

   task automatic put_header(input logic [15:0] id, input logic [31:0] len);
      put_le({16'd0, id}, 2);
      put_le(len, 4);
   endtask

   task automatic put_random(input int nbytes);
      repeat (nbytes) file_bytes.push_back(8'($urandom));
   endtask

   // Mostly well-formed files with random content; some cut short.
   task automatic build_file();
      int          n_chunks;
      int          count;
      int          entries;
      int          entry_bytes;
      int          cut;
      logic [15:0] id;
      logic [31:0] len;
      bit          stop;
      file_bytes.delete();
      stop = 1'b0;
      put_header(ID_MAIN, $urandom);
      put_header(ID_EDITOR, $urandom);
      n_chunks = int'($urandom_range(2, 8));
      for (int k = 0; k < n_chunks && !stop; k++) begin
         case ($urandom_range(0, 6))
            0: begin
               case ($urandom_range(0, 4))
                  0: id = ID_MAIN;
                  1: id = ID_EDITOR;
                  2: id = ID_TRIMESH;
                  3: id = ID_MATERIAL;
                  default: id = ID_MAT_AMB;
               endcase
               put_header(id, $urandom);
            end
            1, 6: begin
               put_header($urandom_range(0, 1) ? ID_OBJECT : ID_MAT_NAME, $urandom);
               repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(1, 255)));
               file_bytes.push_back(8'h00);
               if ($urandom_range(0, 1)) put_header(ID_TRIMESH, $urandom);
            end
            2, 3, 4: begin
               case ($urandom_range(0, 2))
                  0: begin id = ID_VERTICES; entry_bytes = 12; end
                  1: begin id = ID_FACES; entry_bytes = 8; end
                  default: begin id = ID_UVS; entry_bytes = 8; end
               endcase
               if ($urandom_range(0, 11) == 0) begin
                  // huge count, file ends inside the list
                  count   = int'($urandom_range(0, 65535));
                  entries = int'($urandom_range(0, 3));
                  stop    = 1'b1;
               end else begin
                  count   = int'($urandom_range(0, 3));
                  entries = count;
               end
               put_header(id, 32'(8 + count * entry_bytes));
               put_le(32'(count), 2);
               put_random(entries * entry_bytes);
            end
            default: begin
               id = 16'($urandom);
               if ($urandom_range(0, 9) == 0) begin
                  len  = $urandom;
                  stop = 1'b1;
                  put_header(id, len);
                  put_random(int'($urandom_range(0, 20)));
               end else begin
                  len = $urandom_range(0, 14);
                  put_header(id, len);
                  put_random((len > 6) ? int'(len) - 6 : 0);
               end
            end
         endcase
      end
      if ($urandom_range(0, 5) == 0) begin
         cut = int'($urandom_range(1, file_bytes.size()));
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   // Receiver: random stall after each record, with free-running stretches.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 49) == 0) rsp_free_run = ~rsp_free_run;
         rsp_stall = rsp_free_run ? 0 : int'($urandom_range(0, 5));
      end
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Record checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_records.size() == 0) begin
            $error("record_kind: expected no record, got %0d", rsp_tuser);
            error_count++;
         end else begin
            got_rec = pending_records.pop_front();
            if (rsp_tuser !== got_rec.record_kind) begin
               $error("record_kind: expected %0d, got %0d", got_rec.record_kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== got_rec.element_index) begin
               $error("element_index: expected %0d, got %0d",
                      got_rec.element_index, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[17:16] !== got_rec.component) begin
               $error("component: expected %0d, got %0d",
                      got_rec.component, rsp_tdata[17:16]);
               error_count++;
            end
            if (rsp_tdata[49:18] !== got_rec.record_value) begin
               $error("record_value: expected %h, got %h",
                      got_rec.record_value, rsp_tdata[49:18]);
               error_count++;
            end
         end
      end
   end

   initial begin
      int  random_sent;
      int  drain_cycles;
      bit  noise;
      logic fin;
      random_sent = 0;
      clear_parse_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].rec);

      while (random_sent < RANDOM_BYTES) begin
         req_no_gaps = ($urandom_range(0, 3) == 0);
         noise = ($urandom_range(0, 7) == 0);
         if (noise) begin
            file_bytes.delete();
            put_random(int'($urandom_range(1, 30)));
         end else begin
            build_file();
         end
         foreach (file_bytes[i]) begin
            fin = (i == file_bytes.size() - 1) || (noise && $urandom_range(0, 15) == 0);
            send_byte(file_bytes[i], fin, 1'b0, NO_REC);
         end
         random_sent += file_bytes.size();
      end
      req_tvalid <= 1'b0;

      drain_cycles = 0;
      while (pending_records.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_records.size() != 0) begin
         $error("record_kind: expected %0d, got no record (%0d left over)",
                pending_records[0].record_kind, pending_records.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
